// File: rtl/ffsa_pkg.sv
package ffsa_pkg;
  localparam int MaxSegments = 32;
  localparam int SizeW = 20;
  localparam int IdW = 8;
  localparam int CntW = $clog2(MaxSegments + 1);
  localparam int IdxW = $clog2(MaxSegments);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [IdW-1:0]   owner;
    logic             free;
  } seg_t;

  // Table edit applied by every cell in the same cycle
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,   // entries above pos move up one; pos+1 gets ins_seg
    OP_DROP      // entry pos removed; entries above move down one
  } edit_op_t;

  typedef struct packed {
    edit_op_t         op;
    logic [IdxW-1:0]  pos;
    logic             wr_en;    // overwrite entry wr_pos with wr_seg
    logic [IdxW-1:0]  wr_pos;
    seg_t             wr_seg;
    seg_t             ins_seg;
  } edit_t;
endpackage

// File: rtl/ffsa_cell.sv
module ffsa_cell (
  input  logic                      clk,
  input  logic [ffsa_pkg::IdxW-1:0] my_idx,
  input  ffsa_pkg::edit_t           edit,
  input  ffsa_pkg::seg_t            from_lower,
  input  ffsa_pkg::seg_t            from_upper,
  output ffsa_pkg::seg_t            seg
);
  import ffsa_pkg::*;

  seg_t seg_r, seg_nxt;

  // One table entry; shifts toward its neighbors on insert or drop
  always_comb begin
    seg_nxt = seg_r;
    unique case (edit.op)
      OP_INSERT: begin
        if (my_idx > edit.pos + IdxW'(1)) seg_nxt = from_lower;
        else if (my_idx == edit.pos + IdxW'(1)) seg_nxt = edit.ins_seg;
      end
      OP_DROP: begin
        if (my_idx >= edit.pos) seg_nxt = from_upper;
      end
      default: ;
    endcase
    if (edit.wr_en && edit.wr_pos == my_idx) seg_nxt = edit.wr_seg;
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign seg = seg_r;
endmodule

// File: rtl/first_fit_segment_allocator.sv
// Channel | Direction | Beat contents (low bit first)
// in_     | slave     | tdata: request_size[19:0], owner_id[27:20]; tuser: func
// out_    | master    | tdata: status[1:0]
// cfg_    | write     | cfg_wdata: total_size
// From the accepting edge the status is posted after a scan that inspects one
// cell per cycle, then an edit state that applies the insert/drop edit (appends
// from the tail use the same edit state). Freeing with merges on both sides
// adds a merge state after the edit.
// rst_n (synchronous, low) empties the table and restores total_size 1024.
// The result sits in an output register; a new beat is taken only once the
// previous status has been delivered.
module first_fit_segment_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_size[19:0], owner_id[27:20]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // status[1:0]
  input  logic        cfg_wen,
  input  logic [19:0] cfg_wdata   // total_size
);
  import ffsa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EDIT, S_MERGE, S_DONE} state_t;

  state_t           state_r;
  logic [SizeW-1:0] tail_r, req_r;
  logic [IdW-1:0]   id_r;
  logic             func_r;
  logic [CntW-1:0]  cnt_r, scan_r;
  logic [1:0]       status_r;
  logic [IdxW-1:0]  hit_r;
  edit_t            edit;
  seg_t             segs [MaxSegments];
  seg_t             cur, prv;
  logic [IdxW-1:0]  sidx;

  // Row of cells with neighbor links
  for (genvar g = 0; g < MaxSegments; g++) begin : g_cell
    seg_t lo, up;
    if (g == 0) begin : g_lo0
      assign lo = '0;
    end else begin : g_lo
      assign lo = segs[g-1];
    end
    if (g == MaxSegments - 1) begin : g_upn
      assign up = '0;
    end else begin : g_up
      assign up = segs[g+1];
    end
    ffsa_cell u_cell (
      .clk(clk), .my_idx(IdxW'(g)), .edit(edit),
      .from_lower(lo), .from_upper(up), .seg(segs[g])
    );
  end

  assign sidx = scan_r[IdxW-1:0];
  assign cur  = segs[sidx];
  assign prv  = segs[hit_r - IdxW'(1)];

  assign in_tready  = (state_r == S_IDLE) && !out_tvalid;
  assign out_tdata  = {6'd0, status_r};

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // Edit issued to the cells
  always_comb begin
    edit = '0;
    edit.op = OP_NONE;
    if (state_r == S_EDIT) begin
      if (func_r == FUNC_ALLOC) begin
        edit.wr_en = 1'b1;
        edit.wr_pos = hit_r;
        edit.wr_seg = '{size: req_r, owner: id_r, free: 1'b0};
        if (segs[hit_r].size != req_r && hit_r != cnt_r[IdxW-1:0]) begin
          edit.op = OP_INSERT;
          edit.pos = hit_r;
          edit.ins_seg = '{size: segs[hit_r].size - req_r, owner: '0, free: 1'b1};
        end
      end else begin
        edit.wr_en = 1'b1;
        edit.wr_pos = hit_r;
        edit.wr_seg = '{size: segs[hit_r].size, owner: '0, free: 1'b1};
        if (CntW'(hit_r) + CntW'(1) < cnt_r && segs[hit_r+IdxW'(1)].free) begin
          edit.op = OP_DROP;
          edit.pos = hit_r + IdxW'(1);
          edit.wr_seg.size = SizeW'(segs[hit_r].size + segs[hit_r+IdxW'(1)].size);
        end
      end
    end else if (state_r == S_MERGE) begin
      edit.wr_en = 1'b1;
      edit.wr_pos = hit_r - IdxW'(1);
      edit.wr_seg = '{size: SizeW'(prv.size + segs[hit_r].size), owner: '0, free: 1'b1};
      edit.op = OP_DROP;
      edit.pos = hit_r;
    end
  end

  logic drop_hi;
  assign drop_hi = (edit.op == OP_DROP) && (state_r == S_EDIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tail_r <= SizeW'(1024);
      cnt_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (cfg_wen) begin
        tail_r <= cfg_wdata;
        cnt_r <= '0;
      end
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          func_r <= in_tuser;
          req_r <= in_tdata[SizeW-1:0];
          id_r <= in_tdata[SizeW+IdW-1:SizeW];
          scan_r <= '0;
          state_r <= S_SCAN;
          if (in_tuser == FUNC_ALLOC && in_tdata[SizeW-1:0] == '0) begin
            status_r <= ST_NOSPACE;
            state_r <= S_DONE;
          end
        end
        S_SCAN: begin
          if (scan_r < cnt_r) begin
            if (func_r == FUNC_ALLOC && cur.free && cur.size >= req_r) begin
              hit_r <= sidx;
              if (cur.size != req_r && cnt_r == CntW'(MaxSegments)) begin
                status_r <= ST_FULL;
                state_r <= S_DONE;
              end else begin
                status_r <= ST_OK;
                state_r <= S_EDIT;
              end
            end else if (func_r == FUNC_FREE && !cur.free && cur.owner == id_r) begin
              hit_r <= sidx;
              status_r <= ST_OK;
              state_r <= S_EDIT;
            end
            scan_r <= scan_r + CntW'(1);
          end else if (func_r == FUNC_FREE) begin
            status_r <= ST_NOTFOUND;
            state_r <= S_DONE;
          end else if (req_r > tail_r) begin
            status_r <= ST_NOSPACE;
            state_r <= S_DONE;
          end else if (cnt_r == CntW'(MaxSegments)) begin
            status_r <= ST_FULL;
            state_r <= S_DONE;
          end else begin
            // append from tail: the edit cycle writes the new entry at cnt
            hit_r <= cnt_r[IdxW-1:0];
            tail_r <= tail_r - req_r;
            status_r <= ST_OK;
            state_r <= S_EDIT;
          end
        end
        S_EDIT: begin
          if (edit.op == OP_INSERT || (func_r == FUNC_ALLOC && CntW'(hit_r) == cnt_r))
            cnt_r <= cnt_r + CntW'(1);
          if (drop_hi) cnt_r <= cnt_r - CntW'(1);
          state_r <= (func_r == FUNC_FREE && hit_r != '0 && prv.free) ? S_MERGE : S_DONE;
        end
        S_MERGE: begin
          cnt_r <= cnt_r - CntW'(1);
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_tvalid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxSegments)) else $error("segment count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("took a beat while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> (func_r == FUNC_FREE)) else $error("merge on allocate");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("status dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_tvalid) else $error("status not posted");
endmodule
